FILE: rtl/block_variance_macros.svh
// Assertion macros for the block_variance design.
// Included by the top level; expects i_clk and i_rst_n in scope.
`ifndef BLOCK_VARIANCE_MACROS_SVH
`define BLOCK_VARIANCE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BVAR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BVAR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bvar_pkg.sv
// Package for the block variance design: word types and default sizes.
// Used by every module of the block but bvar_div; depends on nothing.
package bvar_pkg;

    localparam int SAMPLE_W = 10;
    localparam int VAR_W    = 20;
    localparam int CNT_W    = 7;

    localparam int DEF_MAX_SAMPLES = 64;
    localparam int DEF_SAMPLE_BITS = 10;

    // Depth of the job queue between the front and the back end.
    localparam int JOB_DEPTH = 2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } t_in_word;

    typedef struct packed {
        logic [VAR_W-1:0] variance;
        logic [CNT_W-1:0] sample_count;
        logic             overflow;
    } t_out_word;

endpackage

FILE: rtl/bvar_fifo.sv
// Short job queue between the front and the back end of the block.
// Depends on bvar_pkg for its depth.
module bvar_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    import bvar_pkg::*;

    localparam int PW = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;

    logic [W-1:0]  r_mem [JOB_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;

    assign o_full  = (r_count == (PW+1)'(JOB_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(JOB_DEPTH - 1)) ? '0 : PW'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(JOB_DEPTH - 1)) ? '0 : PW'(r_rd_ptr + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_count <= (PW+1)'(r_count + 1'b1);
            end else if (!i_push && i_pop) begin
                r_count <= (PW+1)'(r_count - 1'b1);
            end
        end
    end

endmodule

FILE: rtl/bvar_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Shared by the mean and the variance steps of the back end; no package use.
module bvar_div #(
    parameter int DVD_W = 32,
    parameter int DVS_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);
    localparam int CNTW = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNTW-1:0]  r_cnt;
    logic [DVD_W-1:0] r_q;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   n_rem;
    logic             ge;

    always_comb begin
        rem_sh = {r_rem, r_q[DVD_W-1]};
        ge     = (rem_sh >= {1'b0, r_dvs});
        n_rem  = ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_dividend;
                r_dvs  <= i_divisor;
                r_rem  <= '0;
                r_cnt  <= CNTW'(DVD_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= {r_q[DVD_W-2:0], ge};
                r_rem <= n_rem[DVS_W-1:0];
                r_cnt <= CNTW'(r_cnt - 1'b1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/bvar_front.sv
// Front end: accepts sample words, fills one store bank and keeps the running sum.
// Hands each finished set to the job queue. Depends on bvar_pkg.
module bvar_front #(
    parameter int MAX_SAMPLES = bvar_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = bvar_pkg::DEF_SAMPLE_BITS,
    localparam int CW = $clog2(MAX_SAMPLES + 1),
    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
    localparam int SW = SAMPLE_BITS + CW,
    localparam int JW = SW + CW + 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  bvar_pkg::t_in_word     i_in_word,
    output logic                   o_wr_en,
    output logic [AW:0]            o_wr_addr,
    output logic [SAMPLE_BITS-1:0] o_wr_data,
    output logic                   o_job_push,
    output logic [JW-1:0]          o_job,
    input  logic                   i_job_full,
    input  logic [1:0]             i_release
);
    import bvar_pkg::*;

    localparam int SX = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

    logic                   r_bank;
    logic [1:0]             r_busy;
    logic [CW-1:0]          r_count;
    logic [SW-1:0]          r_sum;
    logic                   r_drop;

    logic [1:0]             n_busy;
    logic [CW-1:0]          n_count;
    logic [SW-1:0]          n_sum;
    logic                   n_drop;

    logic                   accept;
    logic                   full;
    logic                   store;
    logic [SX-1:0]          ext;
    logic [SAMPLE_BITS-1:0] smp;

    always_comb begin
        o_in_stall = r_busy[r_bank] || i_job_full;
        accept     = i_in_valid && !o_in_stall;
        full       = (r_count == CW'(MAX_SAMPLES));
        ext        = SX'(i_in_word.sample);
        smp        = ext[SAMPLE_BITS-1:0];
        store      = accept && !full;
        n_count    = store ? CW'(r_count + 1'b1) : r_count;
        n_sum      = store ? SW'(r_sum + SW'(smp)) : r_sum;
        n_drop     = r_drop || (accept && full);
        o_job_push = accept && i_in_word.last;
        o_job      = {r_bank, n_count, n_sum, n_drop};
        o_wr_en    = store;
        o_wr_addr  = {r_bank, r_count[AW-1:0]};
        o_wr_data  = smp;
        n_busy     = (r_busy & ~i_release) | (o_job_push ? 2'(2'b01 << r_bank) : 2'b00);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank  <= 1'b0;
            r_busy  <= 2'b00;
            r_count <= '0;
            r_sum   <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (accept) begin
                if (i_in_word.last) begin
                    r_count <= '0;
                    r_sum   <= '0;
                    r_drop  <= 1'b0;
                    r_bank  <= ~r_bank;
                end else begin
                    r_count <= n_count;
                    r_sum   <= n_sum;
                    r_drop  <= n_drop;
                end
            end
        end
    end

endmodule

FILE: rtl/bvar_back.sv
// Back end: holds the two-bank sample store, runs the mean, squared-deviation
// and variance steps, and drives the output register. Depends on bvar_pkg, bvar_div.
module bvar_back #(
    parameter int MAX_SAMPLES = bvar_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = bvar_pkg::DEF_SAMPLE_BITS,
    localparam int CW = $clog2(MAX_SAMPLES + 1),
    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
    localparam int SW = SAMPLE_BITS + CW,
    localparam int JW = SW + CW + 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr_en,
    input  logic [AW:0]            i_wr_addr,
    input  logic [SAMPLE_BITS-1:0] i_wr_data,
    input  logic [JW-1:0]          i_job,
    input  logic                   i_job_empty,
    output logic                   o_job_pop,
    output logic [1:0]             o_release,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output bvar_pkg::t_out_word    o_out_word
);
    import bvar_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int QW  = 2 * SB + CW;
    localparam int XW  = (QW > VAR_W) ? QW : VAR_W;
    localparam int CX  = (CW > CNT_W) ? CW : CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MEAN,
        S_SQ,
        S_VAR,
        S_OUT
    } t_state;

    t_state            r_state;
    logic [SB-1:0]     r_mem [2**(AW+1)];
    logic [SB-1:0]     r_rd_data;
    logic              r_v1;
    logic              r_v2;
    logic              r_v3;
    logic [SB-1:0]     r_diff;
    logic [2*SB-1:0]   r_sq;
    logic [QW-1:0]     r_acc;
    logic              r_bank;
    logic [CW-1:0]     r_n;
    logic              r_drop;
    logic [SB-1:0]     r_mean;
    logic [CW-1:0]     r_rd_cnt;
    t_out_word         r_res;
    t_out_word         r_out;
    logic              r_out_valid;

    logic              job_bank;
    logic [CW-1:0]     job_cnt;
    logic [SW-1:0]     job_sum;
    logic              job_drop;
    logic              rd_en;
    logic [AW:0]       rd_addr;
    logic              sq_done;
    logic              div_start;
    logic [QW-1:0]     div_dvd;
    logic [CW-1:0]     div_dvs;
    logic              div_done;
    logic [QW-1:0]     div_q;
    logic [XW-1:0]     var_x;
    logic [VAR_W-1:0]  var_sat;
    logic [CX-1:0]     cnt_x;
    logic [CNT_W-1:0]  cnt_sat;

    always_comb begin
        job_bank  = i_job[JW-1];
        job_cnt   = i_job[JW-2 -: CW];
        job_sum   = i_job[SW:1];
        job_drop  = i_job[0];
        o_job_pop = (r_state == S_IDLE) && !i_job_empty;
        rd_en     = (r_state == S_SQ) && (r_rd_cnt != r_n);
        rd_addr   = {r_bank, r_rd_cnt[AW-1:0]};
        sq_done   = (r_state == S_SQ) && !rd_en && !r_v1 && !r_v2 && !r_v3;
        o_release = sq_done ? 2'(2'b01 << r_bank) : 2'b00;
        div_start = o_job_pop || sq_done;
        div_dvd   = (r_state == S_IDLE) ? QW'(job_sum) : r_acc;
        div_dvs   = (r_state == S_IDLE) ? job_cnt : r_n;
        var_x     = XW'(div_q);
        if (r_n == '0) begin
            var_sat = '0;
        end else if (var_x > XW'({VAR_W{1'b1}})) begin
            var_sat = '1;
        end else begin
            var_sat = var_x[VAR_W-1:0];
        end
        cnt_x   = CX'(r_n);
        cnt_sat = (cnt_x > CX'({CNT_W{1'b1}})) ? '1 : cnt_x[CNT_W-1:0];
    end

    bvar_div #(
        .DVD_W (QW),
        .DVS_W (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Sample store: the front end writes one bank while this side reads the other.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= rd_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (r_v1) begin
                r_diff <= (r_rd_data >= r_mean) ? SB'(r_rd_data - r_mean)
                                                : SB'(r_mean - r_rd_data);
            end
            if (r_v2) begin
                r_sq <= r_diff * r_diff;
            end
            if (r_v3) begin
                r_acc <= QW'(r_acc + QW'(r_sq));
            end
            // In S_OUT the valid flag is handled by the state below.
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_job_pop) begin
                        r_bank  <= job_bank;
                        r_n     <= job_cnt;
                        r_drop  <= job_drop;
                        r_state <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    if (div_done) begin
                        r_mean   <= div_q[SB-1:0];
                        r_rd_cnt <= '0;
                        r_acc    <= '0;
                        r_state  <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (rd_en) begin
                        r_rd_cnt <= CW'(r_rd_cnt + 1'b1);
                    end
                    if (sq_done) begin
                        r_state <= S_VAR;
                    end
                end
                S_VAR: begin
                    if (div_done) begin
                        r_res.variance     <= var_sat;
                        r_res.sample_count <= cnt_sat;
                        r_res.overflow     <= r_drop;
                        r_state            <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

FILE: rtl/block_variance.sv
// block_variance: population variance of a set of unsigned converter samples.
// Top level; depends on bvar_pkg, bvar_front, bvar_fifo, bvar_back and the macro header.
//
// The input channel carries one sample word per handshake; a word with last set
// closes the set. The output channel carries one result word per set: the
// variance (sum of squared deviations from the truncated mean, divided by the
// count and truncated), the sample count and an overflow flag for dropped
// samples. Samples beyond MAX_SAMPLES in a set are dropped and flagged.
// Samples are taken one per cycle while the input is not stalled. The store has two banks, so the next set
// fills one bank while the previous set is worked on from the other; the input
// stalls only when both banks hold unfinished sets.
// From the last word to its result, the back end makes two passes of the shared
// bit-serial divider (QW = 2*SAMPLE_BITS + clog2(MAX_SAMPLES+1) dividend bits)
// and one pass over the stored samples.
// Reset clears the counts, sums, flags, the job queue and the output valid;
// the store itself is not cleared, since only written entries are read.
// When the receiver stalls, the result word holds in the output register and
// the back end waits with its next result; the front keeps taking samples
// until both banks are full.
`include "block_variance_macros.svh"

module block_variance #(
    parameter int MAX_SAMPLES = bvar_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = bvar_pkg::DEF_SAMPLE_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bvar_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bvar_pkg::t_out_word o_out_word
);
    import bvar_pkg::*;

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int SW = SAMPLE_BITS + CW;
    localparam int JW = SW + CW + 2;

    logic                   wr_en;
    logic [AW:0]            wr_addr;
    logic [SAMPLE_BITS-1:0] wr_data;
    logic                   job_push;
    logic [JW-1:0]          job_in;
    logic                   job_full;
    logic                   job_pop;
    logic [JW-1:0]          job_out;
    logic                   job_empty;
    logic [1:0]             bank_release;

    // Front end: takes sample words and writes the bank being filled.
    bvar_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_job_push (job_push),
        .o_job      (job_in),
        .i_job_full (job_full),
        .i_release  (bank_release)
    );

    // Finished sets wait here until the back end is free.
    bvar_fifo #(
        .W (JW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    // Back end: mean, squared deviations, variance and the output register.
    bvar_back #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_job       (job_out),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .o_release   (bank_release),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // A full queue means both banks hold sets, so the input must be stalled.
    `BVAR_ASSERT_SAME(a_full_stalls_input, job_full, o_in_stall, "queue full without input stall")
    `BVAR_ASSERT_SAME(a_push_not_full, job_push, !job_full, "set pushed into a full queue")
    `BVAR_ASSERT_SAME(a_pop_not_empty, job_pop, !job_empty, "set popped from an empty queue")
    `BVAR_ASSERT_SAME(a_release_onehot, 1'b1, $onehot0(bank_release), "two banks released at once")
    // After a bank is released the back end is dividing, so it cannot take a set.
    `BVAR_ASSERT_NEXT(a_no_pop_after_release, bank_release != 2'b00, !job_pop, "pop during divide")

endmodule
